// ===== hdl/directional_overcurrent_pickup_top_macros.svh =====
// Assertion helpers for the RTL files, included by dop_ctrl.
`ifndef DIRECTIONAL_OVERCURRENT_PICKUP_TOP_MACROS_SVH
`define DIRECTIONAL_OVERCURRENT_PICKUP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DOP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DOP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dop_pkg.sv =====
package dop_pkg;

	// CORDIC vector width: magnitude << 8 with gain growth and differences
	localparam int XW = 30;
	localparam int ATAN_LEN = 24;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROT_LOAD,
		S_ROT_RUN,
		S_ROT_STORE,
		S_VEC_LOAD,
		S_VEC_RUN,
		S_EVAL,
		S_COMMIT
	} state_t;

	typedef enum logic [1:0] {
		REG_PICKUP_LEVEL = 2'd0,
		REG_TORQUE_ANGLE = 2'd1,
		REG_REVERSE_DIR  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic       latch_in;
		logic       rot_load;
		logic       rot_step;
		logic       rot_store;
		logic       vec_load;
		logic       vec_step;
		logic       eval;
		logic       commit;
		logic [1:0] phase;
	} cmd_t;

	// atan(2^-i) in 32-bit binary angle units
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/dop_ctrl.sv =====
module dop_ctrl
	import dop_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int ITER_W = $clog2(CORDIC_ITERATIONS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output cmd_t              cmd,
	output logic [ITER_W-1:0] iter
);

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERATIONS - 1);
	localparam logic [1:0]        LAST_PHASE = 2'd2;

	state_t            state_q, state_d;
	logic [1:0]        phase_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign iter      = iter_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_ROT_LOAD;
			S_ROT_LOAD:  state_d = S_ROT_RUN;
			S_ROT_RUN:   if (iter_q == LAST_ITER) state_d = S_ROT_STORE;
			S_ROT_STORE: state_d = (phase_q == LAST_PHASE) ? S_VEC_LOAD : S_ROT_LOAD;
			S_VEC_LOAD:  state_d = S_VEC_RUN;
			S_VEC_RUN:   if (iter_q == LAST_ITER) state_d = S_EVAL;
			S_EVAL:      state_d = (phase_q == LAST_PHASE) ? S_COMMIT : S_VEC_LOAD;
			S_COMMIT:    if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.phase = phase_q;
		case (state_q)
			S_IDLE:      cmd.latch_in  = in_valid;
			S_ROT_LOAD:  cmd.rot_load  = 1'b1;
			S_ROT_RUN:   cmd.rot_step  = 1'b1;
			S_ROT_STORE: cmd.rot_store = 1'b1;
			S_VEC_LOAD:  cmd.vec_load  = 1'b1;
			S_VEC_RUN:   cmd.vec_step  = 1'b1;
			S_EVAL:      cmd.eval      = 1'b1;
			S_COMMIT:    cmd.commit    = out_free;
			default:     cmd = '0;
		endcase
	end

	// state, phase and iteration counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_ROT_RUN || state_q == S_VEC_RUN) && iter_q != LAST_ITER)
				iter_q <= iter_q + 1'b1;
			else
				iter_q <= '0;
			if (state_q == S_IDLE)
				phase_q <= '0;
			else if (state_q == S_ROT_STORE || state_q == S_EVAL)
				phase_q <= (phase_q == LAST_PHASE) ? 2'd0 : phase_q + 2'd1;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`include "directional_overcurrent_pickup_top_macros.svh"

	`DOP_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_q == S_ROT_LOAD, "accept did not start rotation")
	`DOP_ASSERT_NEXT(a_result_held, out_valid_q && out_stall, out_valid_q, "stalled result dropped")
	`DOP_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_q && state_q == S_IDLE, "commit not shown")
	`DOP_ASSERT_NOW(a_iter_idle, state_q != S_ROT_RUN && state_q != S_VEC_RUN, iter_q == '0, "iteration count leaked")

endmodule

// ===== hdl/dop_datapath.sv =====
module dop_datapath
	import dop_pkg::*;
#(
	parameter int ITER_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [ITER_W-1:0] iter,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic [15:0]       current_mag_a,
	input  logic [15:0]       current_mag_b,
	input  logic [15:0]       current_mag_c,
	input  logic signed [15:0] current_ang_a,
	input  logic signed [15:0] current_ang_b,
	input  logic signed [15:0] current_ang_c,
	input  logic [15:0]       voltage_mag_a,
	input  logic [15:0]       voltage_mag_b,
	input  logic [15:0]       voltage_mag_c,
	input  logic signed [15:0] voltage_ang_a,
	input  logic signed [15:0] voltage_ang_b,
	input  logic signed [15:0] voltage_ang_c,
	output logic [2:0]        flags,
	output logic              changed
);

	logic [15:0]          pickup_level_q;
	logic [15:0]          torque_angle_q;
	logic                 reverse_q;
	logic [15:0]          imag_q [3];
	logic [15:0]          iang_q [3];
	logic [15:0]          vmag_q [3];
	logic [15:0]          vang_q [3];
	logic signed [XW-1:0] vx_q [3];
	logic signed [XW-1:0] vy_q [3];
	logic signed [XW-1:0] x_q, y_q;
	logic [31:0]          z_q;
	logic                 zero_q;
	logic [2:0]           new_q;
	logic [2:0]           prev_q;
	logic [2:0]           flags_q;
	logic                 changed_q;

	logic signed [XW-1:0] xs, ys, dx, dy, x0;
	logic [31:0]          z0, atan_i;
	logic [15:0]          pol, refa, diff;
	logic [16:0]          amag;
	logic                 dir_ok;

	assign xs     = x_q >>> iter;
	assign ys     = y_q >>> iter;
	assign atan_i = atan_entry(5'(iter));

	// rotation start: fold angles in the left half plane
	always_comb begin
		x0 = XW'(signed'({1'b0, vmag_q[cmd.phase], 8'd0}));
		z0 = {vang_q[cmd.phase], 16'd0};
		if (z0[31:30] == 2'd1 || z0[31:30] == 2'd2) begin
			z0 = z0 + 32'h80000000;
			x0 = -x0;
		end
	end

	// quadrature polarizing difference for the current phase
	always_comb begin
		case (cmd.phase)
			2'd0: begin
				dx = vx_q[1] - vx_q[2];
				dy = vy_q[1] - vy_q[2];
			end
			2'd1: begin
				dx = vx_q[2] - vx_q[0];
				dy = vy_q[2] - vy_q[0];
			end
			default: begin
				dx = vx_q[0] - vx_q[1];
				dy = vy_q[0] - vy_q[1];
			end
		endcase
	end

	// direction test
	always_comb begin
		pol    = zero_q ? 16'd0 : 16'((z_q + 32'h8000) >> 16);
		refa   = pol + torque_angle_q;
		diff   = iang_q[cmd.phase] - refa;
		amag   = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
		dir_ok = reverse_q ? (amag > 17'd16384) : (amag < 17'd16384);
	end

	// configuration registers and result state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pickup_level_q <= 16'hFFFF;
			torque_angle_q <= 16'd0;
			reverse_q      <= 1'b0;
			prev_q         <= 3'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PICKUP_LEVEL: pickup_level_q <= cfg_data;
					REG_TORQUE_ANGLE: torque_angle_q <= cfg_data;
					REG_REVERSE_DIR:  reverse_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.commit)
				prev_q <= new_q;
		end
	end

	// snapshot, CORDIC unit and pickup accumulation
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			imag_q[0] <= current_mag_a;
			imag_q[1] <= current_mag_b;
			imag_q[2] <= current_mag_c;
			iang_q[0] <= current_ang_a;
			iang_q[1] <= current_ang_b;
			iang_q[2] <= current_ang_c;
			vmag_q[0] <= voltage_mag_a;
			vmag_q[1] <= voltage_mag_b;
			vmag_q[2] <= voltage_mag_c;
			vang_q[0] <= voltage_ang_a;
			vang_q[1] <= voltage_ang_b;
			vang_q[2] <= voltage_ang_c;
			new_q     <= 3'd0;
		end
		if (cmd.rot_load) begin
			x_q <= x0;
			y_q <= '0;
			z_q <= z0;
		end
		if (cmd.rot_step) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_i;
			end
		end
		if (cmd.rot_store) begin
			vx_q[cmd.phase] <= x_q;
			vy_q[cmd.phase] <= y_q;
		end
		if (cmd.vec_load) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				x_q <= -dx;
				y_q <= -dy;
				z_q <= 32'h80000000;
			end else begin
				x_q <= dx;
				y_q <= dy;
				z_q <= 32'd0;
			end
		end
		if (cmd.vec_step) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_i;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_i;
			end
		end
		if (cmd.eval)
			new_q[cmd.phase] <= (imag_q[cmd.phase] > pickup_level_q) && dir_ok;
		if (cmd.commit) begin
			flags_q   <= new_q;
			changed_q <= (new_q != prev_q);
		end
	end

	assign flags   = flags_q;
	assign changed = changed_q;

endmodule

// ===== hdl/directional_overcurrent_pickup_top.sv =====
// Directional overcurrent pickup, quadrature polarized.
// Input channel (in_valid/in_stall): one beat is a full phasor snapshot of
// three phase currents and three phase voltages (magnitude and angle each).
// Output channel (out_valid/out_stall): one beat per snapshot with the three
// phase pickup flags, their OR and a flag-changed bit.
// Config channel (cfg_valid/cfg_ready): index 0 pickup level, 1 torque angle,
// 2 reverse direction; other indexes are ignored. cfg_ready is always high.
// One shared CORDIC unit does one micro-rotation per cycle: three rotations
// then three vectoring passes, each a load, the micro-rotations and a store
// or evaluate step, then a commit that waits for the output to be free.
// The result is registered on commit as the block returns to idle, so a
// new snapshot can be accepted while the result beat is still valid.
// in_stall is high while a snapshot is being worked on.
// If the receiver stalls, the result holds; the block can accept and
// process the next snapshot but waits to register it until the beat leaves.
// Reset clears the registers to pickup level 65535, torque 0, forward
// mode, and clears the previous flags kept for the change bit and the output valid.
module directional_overcurrent_pickup_top
	import dop_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       current_mag_a,
	input  logic [15:0]       current_mag_b,
	input  logic [15:0]       current_mag_c,
	input  logic signed [15:0] current_ang_a,
	input  logic signed [15:0] current_ang_b,
	input  logic signed [15:0] current_ang_c,
	input  logic [15:0]       voltage_mag_a,
	input  logic [15:0]       voltage_mag_b,
	input  logic [15:0]       voltage_mag_c,
	input  logic signed [15:0] voltage_ang_a,
	input  logic signed [15:0] voltage_ang_b,
	input  logic signed [15:0] voltage_ang_c,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pickup_phase_a,
	output logic              pickup_phase_b,
	output logic              pickup_phase_c,
	output logic              any_pickup,
	output logic              flags_changed,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int ITER_W = $clog2(CORDIC_ITERATIONS);

	cmd_t              cmd;
	logic [ITER_W-1:0] iter;
	logic [2:0]        flags;

	assign cfg_ready = 1'b1;

	dop_ctrl #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS),
		.ITER_W(ITER_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.iter(iter)
	);

	dop_datapath #(
		.ITER_W(ITER_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.iter(iter),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.current_mag_a(current_mag_a),
		.current_mag_b(current_mag_b),
		.current_mag_c(current_mag_c),
		.current_ang_a(current_ang_a),
		.current_ang_b(current_ang_b),
		.current_ang_c(current_ang_c),
		.voltage_mag_a(voltage_mag_a),
		.voltage_mag_b(voltage_mag_b),
		.voltage_mag_c(voltage_mag_c),
		.voltage_ang_a(voltage_ang_a),
		.voltage_ang_b(voltage_ang_b),
		.voltage_ang_c(voltage_ang_c),
		.flags(flags),
		.changed(flags_changed)
	);

	assign pickup_phase_a = flags[0];
	assign pickup_phase_b = flags[1];
	assign pickup_phase_c = flags[2];
	assign any_pickup     = |flags;

endmodule
